// ----- hw/rtl/sync_frame_receiver_with_resync_macros.svh -----
`ifndef SYNC_FRAME_RECEIVER_WITH_RESYNC_MACROS_SVH
`define SYNC_FRAME_RECEIVER_WITH_RESYNC_MACROS_SVH

// same-cycle implication, sampled on clk, held off during rst
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, held off during rst
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sfr_pkg.sv -----
package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam byte_t SYNC_RESET = 8'hFF;

endpackage

// ----- hw/rtl/sfr_rx_if.sv -----
interface sfr_rx_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/sfr_frame_if.sv -----
interface sfr_frame_if import sfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t frame_byte;
  pos_t  byte_position;
  logic  frame_end;

  modport source (output valid, output frame_byte, output byte_position, output frame_end,
                  input ready);
  modport sink (input valid, input frame_byte, input byte_position, input frame_end,
                output ready);
endinterface

// ----- hw/rtl/sfr_store.sv -----
module sfr_store import sfr_pkg::*; #(
  parameter int FRAME_LEN = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [$clog2(FRAME_LEN)-1:0] wr_off,
  input  byte_t                        wr_data,
  input  logic [$clog2(FRAME_LEN)-1:0] rd_off,
  output byte_t                        rd_data,
  input  logic                         shift_en,
  input  logic [$clog2(FRAME_LEN)-1:0] shift_off
);

  localparam int AW = $clog2(FRAME_LEN);
  localparam logic [AW:0] LEN = (AW+1)'(FRAME_LEN);

  byte_t         mem [FRAME_LEN];
  logic [AW-1:0] base;

  // frame position to physical slot, circular around base
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] b, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, b} + {1'b0, off};
    if (s >= LEN) s = s - LEN;
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (shift_en) begin
      base <= slot(base, shift_off);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot(base, wr_off)] <= wr_data;
    end
    rd_data <= mem[slot(base, rd_off)];
  end

endmodule

// ----- hw/rtl/sync_frame_receiver_with_resync.sv -----
// Sync-byte frame receiver with additive checksum and resynchronisation.
// rx (sink): one received byte per transaction. While no frame is open, bytes
// other than sync_value are dropped; a sync byte opens a frame.
// frame (source): one byte of a good frame per transaction, with its position
// (sync byte is 0) and frame_end on the last byte.
// sync_we/sync_wdata write sync_value; write it only while the block is idle.
// Throughput: a byte that does not complete a frame is taken every cycle.
// The byte that completes a frame starts a check pass over the store memory,
// one read per cycle; rx is held off from then until the block is idle again.
// A good frame then goes out byte by byte, each with a read, a load and a
// handshake step; rx is taken again in the cycle after the last output
// transaction. On a bad checksum the store base moves to the next sync byte
// found, with no copying, or the store is emptied if none is found.
// A stalled frame output simply holds its byte; nothing is lost.
// Reset (rst, synchronous) empties the store and sets sync_value to 8'hFF;
// the store contents themselves are not cleared.
module sync_frame_receiver_with_resync import sfr_pkg::*; #(
  parameter int FRAME_LEN = 48
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  sync_we,
  input  byte_t sync_wdata,
  sfr_rx_if.sink      rx,
  sfr_frame_if.source frame
);

`include "sync_frame_receiver_with_resync_macros.svh"

  localparam int AW = $clog2(FRAME_LEN);
  localparam int FW = $clog2(FRAME_LEN + 1);
  localparam logic [AW-1:0] LAST_POS = AW'(FRAME_LEN - 1);
  localparam logic [AW-1:0] SUM_POS  = AW'(1);
  localparam logic [FW-1:0] FILL_TOP = FW'(FRAME_LEN - 1);
  localparam logic [FW-1:0] FILL_LEN = FW'(FRAME_LEN);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_CHK_END, S_DECIDE, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  state_t        state;
  byte_t         sync_value;
  logic [FW-1:0] fill;
  logic [AW-1:0] idx;
  logic [AW-1:0] pos_d;
  logic          pend;
  byte_t         sum;
  byte_t         chk;
  logic          found;
  logic [AW-1:0] sync_pos;
  logic          out_valid;
  byte_t         out_byte;
  pos_t          out_pos;
  logic          out_end;

  logic          rx_take;
  logic          wr_en;
  logic          shift_en;
  byte_t         rd_data;

  assign rx.ready  = (state == S_IDLE);
  assign rx_take   = rx.valid && rx.ready;
  assign wr_en     = rx_take && !((fill == '0) && (rx.rx_byte != sync_value));
  assign shift_en  = (state == S_DECIDE) && (sum != chk) && found;

  assign frame.valid         = out_valid;
  assign frame.frame_byte    = out_byte;
  assign frame.byte_position = out_pos;
  assign frame.frame_end     = out_end;

  sfr_store #(.FRAME_LEN(FRAME_LEN)) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_off    (fill[AW-1:0]),
    .wr_data   (rx.rx_byte),
    .rd_off    (idx),
    .rd_data   (rd_data),
    .shift_en  (shift_en),
    .shift_off (sync_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sync_value <= SYNC_RESET;
      fill       <= '0;
      idx        <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (sync_we) begin
        sync_value <= sync_wdata;
      end

      // read data from the check pass lands in the cycle after its address
      pend  <= (state == S_CHK);
      pos_d <= idx;
      if (pend) begin
        if (pos_d == SUM_POS) begin
          chk <= rd_data;
        end else begin
          sum <= sum + rd_data;
        end
        if (!found && (rd_data == sync_value)) begin
          found    <= 1'b1;
          sync_pos <= pos_d;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (wr_en) begin
            fill <= fill + 1'b1;
            if (fill == FILL_TOP) begin
              state <= S_CHK;
              idx   <= SUM_POS;
              sum   <= '0;
              found <= 1'b0;
            end
          end
        end
        S_CHK: begin
          if (idx == LAST_POS) begin
            state <= S_CHK_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CHK_END: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sum == chk) begin
            idx   <= '0;
            state <= S_OUT_RD;
          end else begin
            fill  <= found ? (FILL_LEN - FW'(sync_pos)) : '0;
            state <= S_IDLE;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_byte  <= rd_data;
          out_pos   <= POS_W'(idx);
          out_end   <= (idx == LAST_POS);
          out_valid <= 1'b1;
          state     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (frame.ready) begin
            out_valid <= 1'b0;
            if (idx == LAST_POS) begin
              fill  <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SFR_ASSERT_NOW(a_no_rx_while_out, out_valid, !rx.ready, "rx taken while a frame is out")
  `SFR_ASSERT_NOW(a_fill_below_len, state == S_IDLE, fill < FILL_LEN, "store full while idle")
  `SFR_ASSERT_NOW(a_pend_in_check, pend, (state == S_CHK_END) || (state == S_CHK),
                  "check read outside check pass")
  `SFR_ASSERT_NEXT(a_empty_after_frame, frame.valid && frame.ready && frame.frame_end,
                   (fill == '0) && (state == S_IDLE), "store not emptied after frame")

endmodule

// ----- verif/sync_frame_receiver_with_resync_test.sv -----
module sync_frame_receiver_with_resync_test;
  import sfr_pkg::*;

  localparam int FRAME_LEN = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 4 * FRAME_LEN;
  localparam int RANDOM_PHASES = 2;
  localparam int PHASE_BYTES = 24;

  typedef struct packed {
    byte_t data;
    pos_t  pos;
    logic  last;
  } frame_beat_t;

  typedef byte_t frame_bytes_t [FRAME_LEN];

  logic  clk = 1'b0;
  logic  rst;
  logic  sync_we;
  byte_t sync_wdata;

  sfr_rx_if    rx_ch ();
  sfr_frame_if frame_ch ();

  sync_frame_receiver_with_resync #(
    .FRAME_LEN(FRAME_LEN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .sync_we   (sync_we),
    .sync_wdata(sync_wdata),
    .rx        (rx_ch),
    .frame     (frame_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // own copy of the receiver state
  byte_t       store_copy [FRAME_LEN];
  int unsigned fill_copy;
  byte_t       sync_copy;

  frame_beat_t good_frame_beats[$];
  int          mismatch_count;
  int          kept_count;
  int          cycle_count;
  bit          calm;

  // one received byte: returns 1 when the byte was stored, 0 when dropped
  function automatic bit take_rx_byte(input byte_t b);
    byte_t       sum;
    int          i;
    int          p;
    bit          found;
    frame_beat_t beat;
    if (fill_copy == 0) begin
      if (b != sync_copy) return 1'b0;
      store_copy[0] = b;
      fill_copy = 1;
    end else begin
      store_copy[fill_copy] = b;
      fill_copy++;
    end
    if (fill_copy < FRAME_LEN) return 1'b1;
    sum = '0;
    for (i = 2; i < FRAME_LEN; i++) sum = sum + store_copy[i];
    if (sum != store_copy[1]) begin
      // move the frame up to the next sync byte, or empty the store
      found = 1'b0;
      for (p = 1; p < FRAME_LEN; p++) begin
        if (!found && store_copy[p] == sync_copy) begin
          found = 1'b1;
          for (i = 0; i < FRAME_LEN - p; i++) store_copy[i] = store_copy[i + p];
          fill_copy = FRAME_LEN - p;
        end
      end
      if (!found) fill_copy = 0;
      return 1'b1;
    end
    for (i = 0; i < FRAME_LEN; i++) begin
      beat.data = store_copy[i];
      beat.pos  = pos_t'(i);
      beat.last = (i == FRAME_LEN - 1);
      good_frame_beats.push_back(beat);
    end
    fill_copy = 0;
    return 1'b1;
  endfunction

  function automatic byte_t checksum_byte(input frame_bytes_t f, input bit good,
                                          input bit avoid);
    byte_t sum;
    byte_t c;
    int    i;
    sum = '0;
    for (i = 2; i < FRAME_LEN; i++) sum = sum + f[i];
    if (good) return sum;
    c = sum + byte_t'($urandom_range(1, 255));
    while (avoid && c == f[0]) c = sum + byte_t'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic frame_bytes_t random_frame(input byte_t s, input bit good,
                                                input bit avoid);
    frame_bytes_t f;
    int           i;
    f[0] = s;
    for (i = 2; i < FRAME_LEN; i++) begin
      f[i] = byte_t'($urandom_range(255));
      while (avoid && f[i] == s) f[i] = byte_t'($urandom_range(255));
    end
    f[1] = checksum_byte(f, good, avoid);
    return f;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic send_byte(input byte_t b);
    if (!calm && $urandom_range(99) < 6) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    if (take_rx_byte(b)) kept_count++;
  endtask

  task automatic send_frame(input frame_bytes_t f, input int from);
    int i;
    for (i = from; i < FRAME_LEN; i++) send_byte(f[i]);
  endtask

  // block idle: every frame byte out and the check pass finished
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (good_frame_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input byte_t v);
    sync_we    <= 1'b1;
    sync_wdata <= v;
    @(posedge clk);
    sync_we   <= 1'b0;
    sync_copy = v;
  endtask

  task automatic test_default_sync();
    frame_bytes_t f;
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'h7F);
    send_byte(8'h80);
    f = random_frame(SYNC_RESET, 1'b1, 1'b0);
    f[2] = 8'h00;
    f[3] = 8'hFF;
    f[4] = 8'h80;
    f[5] = 8'h01;
    f[6] = 8'h7F;
    f[FRAME_LEN - 1] = SYNC_RESET;
    f[1] = checksum_byte(f, 1'b1, 1'b0);
    send_frame(f, 0);
    settle();
  endtask

  task automatic test_bad_frame_dropped();
    frame_bytes_t f;
    f = random_frame(sync_copy, 1'b0, 1'b1);
    send_frame(f, 0);
    // store is empty again, so this is dropped
    send_byte(8'h12);
    settle();
  endtask

  task automatic test_resync_chain();
    frame_bytes_t first;
    frame_bytes_t second;
    int           k;
    int           j;
    k = $urandom_range(2, FRAME_LEN - 3);
    second = random_frame(sync_copy, 1'b1, 1'b1);
    first = random_frame(sync_copy, 1'b0, 1'b1);
    // tail of the bad frame carries the head of the next one
    for (j = 0; j < k; j++) first[FRAME_LEN - k + j] = second[j];
    first[1] = checksum_byte(first, 1'b0, 1'b1);
    send_frame(first, 0);
    send_frame(second, k);
    settle();
  endtask

  task automatic test_sync_register();
    byte_t        values [2];
    frame_bytes_t f;
    int           n;
    values[0] = 8'h00;
    values[1] = 8'h80;
    for (n = 0; n < 2; n++) begin
      write_sync(values[n]);
      send_byte(~values[n]);
      f = random_frame(values[n], 1'b1, 1'b0);
      f[$urandom_range(2, FRAME_LEN - 1)] = values[n];
      f[1] = checksum_byte(f, 1'b1, 1'b0);
      send_frame(f, 0);
      settle();
    end
  endtask

  task automatic test_random_traffic();
    frame_bytes_t f;
    int           phase;
    int           base;
    int           r;
    int           n;
    int           i;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_sync(byte_t'($urandom_range(255)));
      calm = (phase == 1);
      base = kept_count;
      while (kept_count - base < PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < 75) begin
          f = random_frame(sync_copy, r < 60, 1'b0);
          if ($urandom_range(1)) begin
            f[$urandom_range(2, FRAME_LEN - 1)] = sync_copy;
            f[1] = checksum_byte(f, r < 60, 1'b0);
          end
          send_frame(f, 0);
        end else if (r < 88) begin
          n = $urandom_range(1, 4);
          for (i = 0; i < n; i++) send_byte(byte_t'($urandom_range(255)));
        end else begin
          // broken frame: sync and 1 to FRAME_LEN - 2 random bytes, the rest never comes
          send_byte(sync_copy);
          n = $urandom_range(1, FRAME_LEN - 2);
          for (i = 0; i < n; i++) send_byte(byte_t'($urandom_range(255)));
        end
      end
      calm = 1'b0;
      settle();
    end
  endtask

  // frame side: random back-pressure and checking of every transaction
  always @(posedge clk) begin
    frame_beat_t want;
    frame_ch.ready <= calm || ($urandom_range(99) >= 11);
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (good_frame_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %h pos %0d end %0b",
                                frame_ch.frame_byte, frame_ch.byte_position,
                                frame_ch.frame_end));
      end else begin
        want = good_frame_beats.pop_front();
        if (frame_ch.frame_byte !== want.data || frame_ch.byte_position !== want.pos ||
            frame_ch.frame_end !== want.last) begin
          note_mismatch($sformatf("expected %h pos %0d end %0b, got %h pos %0d end %0b",
                                  want.data, want.pos, want.last, frame_ch.frame_byte,
                                  frame_ch.byte_position, frame_ch.frame_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cycle_count    = 0;
    mismatch_count = 0;
    kept_count     = 0;
    calm           = 1'b0;
    fill_copy      = 0;
    sync_copy      = SYNC_RESET;
    rst            <= 1'b1;
    sync_we        <= 1'b0;
    sync_wdata     <= '0;
    rx_ch.valid    <= 1'b0;
    rx_ch.rx_byte  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_sync();
    test_bad_frame_dropped();
    test_resync_chain();
    test_sync_register();
    test_random_traffic();

    if (mismatch_count == 0 && good_frame_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sync_frame_receiver_with_resync.f -----
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_rx_if.sv
hw/rtl/sfr_frame_if.sv
hw/rtl/sfr_store.sv
hw/rtl/sync_frame_receiver_with_resync.sv
verif/sync_frame_receiver_with_resync_test.sv
